>>> rtl/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// Shared constants, request codes and types of the reader/writer lock manager.
// ----------------------------------------------------------------------------
package rwl_pkg;

	localparam int MODE_W        = 3;
	localparam int HOST_W        = 4;
	localparam int STATE_W       = 2;
	localparam int HOSTS_DEF     = 16;
	localparam int COUNT_BITS_DEF = 8;
	localparam int READER_EXTRA  = 4;

	localparam logic [MODE_W-1:0] MODE_RD_LOCK   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RD_UNLOCK = 3'd1;
	localparam logic [MODE_W-1:0] MODE_WR_LOCK   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_WR_UNLOCK = 3'd3;
	localparam logic [MODE_W-1:0] MODE_UNLOCK    = 3'd4;

	localparam logic [STATE_W-1:0] ST_UNLOCKED = 2'd0;
	localparam logic [STATE_W-1:0] ST_READ     = 2'd1;
	localparam logic [STATE_W-1:0] ST_WRITE    = 2'd2;

	typedef struct packed {
		logic                granted;
		logic                hold_we;
		logic                clr_all;
		logic                reader_we;
		logic [STATE_W-1:0]  state_nx;
	} rwl_dec_t;

endpackage

>>> rtl/rwl_if.sv
// ----------------------------------------------------------------------------
// rwl_req_if / rwl_rsp_if
// Valid/ready channels carrying lock requests and lock results.
// ----------------------------------------------------------------------------
interface rwl_req_if;
	import rwl_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [HOST_W-1:0] host;

	modport source (output valid, output mode, output host, input ready);
	modport sink (input valid, input mode, input host, output ready);
endinterface

interface rwl_rsp_if;
	import rwl_pkg::*;

	logic               valid;
	logic               ready;
	logic               granted;
	logic [STATE_W-1:0] lock_state;

	modport source (output valid, output granted, output lock_state, input ready);
	modport sink (input valid, input granted, input lock_state, output ready);
endinterface

>>> rtl/reader_writer_lock_manager.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_manager
// Reentrant reader/writer lock: per-host hold counters, reader total, mode.
// ----------------------------------------------------------------------------
// A request is taken on req and its result appears on rsp from an output
// register; requests are taken one per cycle back to back as long as rsp
// drains. Each request reads the host's hold counter from the hold memory
// when taken, then is decided and written back once rsp can take the result;
// a write unlock clears every hold counter at once. The lock mode and the
// reader total live in flops. lock_state shows the mode after the request.
module reader_writer_lock_manager #(
	parameter int HOSTS      = rwl_pkg::HOSTS_DEF,
	parameter int COUNT_BITS = rwl_pkg::COUNT_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rwl_req_if.sink   req,
	rwl_rsp_if.source rsp
);
	import rwl_pkg::*;

	localparam int AW = $clog2(HOSTS);
	localparam int RB = COUNT_BITS + READER_EXTRA;

	logic                  busy_s1;
	logic [MODE_W-1:0]     mode_s1;
	logic [AW-1:0]         addr_s1;
	logic                  host_ok_s1;
	logic [STATE_W-1:0]    mode_now_q;
	logic [RB-1:0]         reader_total_q;
	logic                  rsp_valid_q;
	logic                  granted_q;
	logic [STATE_W-1:0]    lock_state_q;

	logic                  acc;
	logic                  done;
	logic [COUNT_BITS-1:0] hold;
	logic [COUNT_BITS-1:0] hold_nx;
	logic [RB-1:0]         reader_nx;
	rwl_dec_t              dec;

	assign done      = busy_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !busy_s1 || done;
	assign acc       = req.valid && req.ready;

	rwl_hold_mem #(
		.HOSTS      (HOSTS),
		.COUNT_BITS (COUNT_BITS),
		.AW         (AW)
	) u_hold_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (AW'(req.host)),
		.wr_en   (done && dec.hold_we),
		.wr_addr (addr_s1),
		.wr_data (hold_nx),
		.clr_all (done && dec.clr_all),
		.rd_data (hold)
	);

	rwl_update #(
		.COUNT_BITS (COUNT_BITS),
		.RB         (RB)
	) u_update (
		.mode         (mode_s1),
		.host_ok      (host_ok_s1),
		.state        (mode_now_q),
		.reader_total (reader_total_q),
		.hold         (hold),
		.dec          (dec),
		.hold_nx      (hold_nx),
		.reader_nx    (reader_nx)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1    <= req.mode;
			addr_s1    <= AW'(req.host);
			host_ok_s1 <= (32'(req.host) < 32'(HOSTS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1        <= 1'b0;
			mode_now_q     <= ST_UNLOCKED;
			reader_total_q <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (acc) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
				mode_now_q  <= dec.state_nx;
				if (dec.reader_we) begin
					reader_total_q <= reader_nx;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			granted_q    <= dec.granted;
			lock_state_q <= dec.state_nx;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.granted    = granted_q;
	assign rsp.lock_state = lock_state_q;

endmodule

>>> rtl/rwl_hold_mem.sv
// ----------------------------------------------------------------------------
// rwl_hold_mem
// Per-host hold counters in a synchronous memory with registered read,
// valid bits for clearing all entries at once, and write forwarding.
// ----------------------------------------------------------------------------
module rwl_hold_mem #(
	parameter int HOSTS      = rwl_pkg::HOSTS_DEF,
	parameter int COUNT_BITS = rwl_pkg::COUNT_BITS_DEF,
	parameter int AW         = $clog2(HOSTS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [COUNT_BITS-1:0] wr_data,
	input  logic                  clr_all,
	output logic [COUNT_BITS-1:0] rd_data
);

	logic [COUNT_BITS-1:0] mem [HOSTS];
	logic [HOSTS-1:0]      valid_q;
	logic [COUNT_BITS-1:0] raw_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic                  fwd_q;
	logic                  vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			raw_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// bypass a write to the entry being read, clear wins over stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
			vld_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
			vld_q <= valid_q[rd_addr] && !clr_all;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (vld_q ? raw_q : '0);

endmodule

>>> rtl/rwl_update.sv
// ----------------------------------------------------------------------------
// rwl_update
// Decides one lock request from the lock mode, reader total and the host's
// hold count, and forms the new values.
// ----------------------------------------------------------------------------
module rwl_update #(
	parameter int COUNT_BITS = rwl_pkg::COUNT_BITS_DEF,
	parameter int RB         = COUNT_BITS + rwl_pkg::READER_EXTRA
) (
	input  logic [rwl_pkg::MODE_W-1:0]  mode,
	input  logic                        host_ok,
	input  logic [rwl_pkg::STATE_W-1:0] state,
	input  logic [RB-1:0]               reader_total,
	input  logic [COUNT_BITS-1:0]       hold,
	output rwl_pkg::rwl_dec_t           dec,
	output logic [COUNT_BITS-1:0]       hold_nx,
	output logic [RB-1:0]               reader_nx
);
	import rwl_pkg::*;

	logic [MODE_W-1:0] eff_mode;
	logic              hold_full;
	logic              hold_zero;
	logic              rt_full;
	logic [RB-1:0]     rt_dec;

	assign hold_full = &hold;
	assign hold_zero = (hold == '0);
	assign rt_full   = &reader_total;
	assign rt_dec    = (reader_total == '0) ? '0 : reader_total - RB'(1);

	always_comb begin
		eff_mode = mode;
		if (mode == MODE_UNLOCK) begin
			if (state == ST_READ) begin
				eff_mode = MODE_RD_UNLOCK;
			end else if (state == ST_WRITE) begin
				eff_mode = MODE_WR_UNLOCK;
			end
		end
	end

	always_comb begin
		dec.granted   = 1'b0;
		dec.hold_we   = 1'b0;
		dec.clr_all   = 1'b0;
		dec.reader_we = 1'b0;
		dec.state_nx  = state;
		hold_nx       = hold + COUNT_BITS'(1);
		reader_nx     = reader_total + RB'(1);
		if (host_ok) begin
			unique case (eff_mode)
				MODE_RD_LOCK: begin
					if ((state == ST_READ || state == ST_UNLOCKED) && !hold_full && !rt_full) begin
						dec.granted   = 1'b1;
						dec.hold_we   = 1'b1;
						dec.reader_we = 1'b1;
						dec.state_nx  = ST_READ;
					end
				end
				MODE_RD_UNLOCK: begin
					hold_nx   = hold - COUNT_BITS'(1);
					reader_nx = rt_dec;
					if (state == ST_READ && !hold_zero) begin
						dec.granted   = 1'b1;
						dec.hold_we   = 1'b1;
						dec.reader_we = 1'b1;
						dec.state_nx  = (rt_dec == '0) ? ST_UNLOCKED : ST_READ;
					end
				end
				MODE_WR_LOCK: begin
					if ((state == ST_UNLOCKED || (state == ST_WRITE && !hold_zero)) && !hold_full) begin
						dec.granted  = 1'b1;
						dec.hold_we  = 1'b1;
						dec.state_nx = ST_WRITE;
					end
				end
				MODE_WR_UNLOCK: begin
					if (state == ST_WRITE && !hold_zero) begin
						dec.granted  = 1'b1;
						dec.clr_all  = 1'b1;
						dec.state_nx = ST_UNLOCKED;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> dv/reader_writer_lock_manager_test.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_manager_test
// Self-checking bench for the reentrant reader/writer lock manager. Requests
// are offered on the req channel and results drained from rsp under random
// idling on both sides. A scoreboard tracks the lock mode, the reader total
// and the per-host hold counts, predicts every result and compares it in
// order. Stimulus covers directed corner cases, reader, writer, contention
// and noise sequences, and saturation of the hold counters.
// ----------------------------------------------------------------------------
class lock_scoreboard;
	typedef struct packed {
		logic                        granted;
		logic [rwl_pkg::STATE_W-1:0] lock_state;
	} lock_result_t;

	logic [rwl_pkg::STATE_W-1:0]                          lock_mode;
	logic [rwl_pkg::COUNT_BITS_DEF+rwl_pkg::READER_EXTRA-1:0] reader_count;
	logic [rwl_pkg::COUNT_BITS_DEF-1:0]                   hold_cnt [rwl_pkg::HOSTS_DEF];
	lock_result_t                                         expected_results [$];
	int unsigned                                          mismatches;
	int unsigned                                          results_checked;
	int unsigned                                          grants_seen;

	function new();
		lock_mode = rwl_pkg::ST_UNLOCKED;
		reader_count = '0;
		foreach (hold_cnt[i]) hold_cnt[i] = '0;
		mismatches = 0;
		results_checked = 0;
		grants_seen = 0;
	endfunction

	function bit release_read(logic [rwl_pkg::HOST_W-1:0] h);
		if (lock_mode != rwl_pkg::ST_READ || hold_cnt[h] == '0) return 1'b0;
		hold_cnt[h] = hold_cnt[h] - 1'b1;
		if (reader_count != '0) reader_count = reader_count - 1'b1;
		if (reader_count == '0) lock_mode = rwl_pkg::ST_UNLOCKED;
		return 1'b1;
	endfunction

	function bit release_write(logic [rwl_pkg::HOST_W-1:0] h);
		if (lock_mode != rwl_pkg::ST_WRITE || hold_cnt[h] == '0) return 1'b0;
		foreach (hold_cnt[i]) hold_cnt[i] = '0;
		lock_mode = rwl_pkg::ST_UNLOCKED;
		return 1'b1;
	endfunction

	// host index always below HOSTS at this width
	function void note_request(logic [rwl_pkg::MODE_W-1:0] m, logic [rwl_pkg::HOST_W-1:0] h);
		lock_result_t r;
		r.granted = 1'b0;
		case (m)
			rwl_pkg::MODE_RD_LOCK: begin
				if ((lock_mode == rwl_pkg::ST_UNLOCKED || lock_mode == rwl_pkg::ST_READ) &&
				    !(&hold_cnt[h]) && !(&reader_count)) begin
					hold_cnt[h] = hold_cnt[h] + 1'b1;
					reader_count = reader_count + 1'b1;
					lock_mode = rwl_pkg::ST_READ;
					r.granted = 1'b1;
				end
			end
			rwl_pkg::MODE_RD_UNLOCK: r.granted = release_read(h);
			rwl_pkg::MODE_WR_LOCK: begin
				if ((lock_mode == rwl_pkg::ST_UNLOCKED ||
				     (lock_mode == rwl_pkg::ST_WRITE && hold_cnt[h] != '0)) && !(&hold_cnt[h])) begin
					hold_cnt[h] = hold_cnt[h] + 1'b1;
					lock_mode = rwl_pkg::ST_WRITE;
					r.granted = 1'b1;
				end
			end
			rwl_pkg::MODE_WR_UNLOCK: r.granted = release_write(h);
			rwl_pkg::MODE_UNLOCK: begin
				if (lock_mode == rwl_pkg::ST_READ) r.granted = release_read(h);
				else if (lock_mode == rwl_pkg::ST_WRITE) r.granted = release_write(h);
			end
			default: ;
		endcase
		r.lock_state = lock_mode;
		expected_results.push_back(r);
	endfunction

	function void check_result(logic g, logic [rwl_pkg::STATE_W-1:0] st);
		lock_result_t want;
		results_checked++;
		if (g === 1'b1) grants_seen++;
		if (expected_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with no request pending: granted=%b lock_state=%0d",
					$realtime, g, st);
			return;
		end
		want = expected_results.pop_front();
		if (want.granted !== g || want.lock_state !== st) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch: granted exp %b got %b, lock_state exp %0d got %0d",
					$realtime, want.granted, g, want.lock_state, st);
		end
	endfunction
endclass

module reader_writer_lock_manager_test;
	import rwl_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int TIMEOUT_CYCLES = 200_000;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int PHASE_ITEMS    = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rwl_req_if req_ch ();
	rwl_rsp_if rsp_ch ();

	reader_writer_lock_manager u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	lock_scoreboard lock_sb = new();

	int unsigned tx_idle_pct = 14;
	int unsigned rx_idle_pct = 56;
	int unsigned phase = 0;
	int unsigned requests_sent = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Simulation FAILED");
		$finish;
	end

	// result side: random stalls plus one long hold-off at the start of the last phase
	initial begin
		int unsigned hold_left;
		bit hold_off_done;
		hold_left = 0;
		hold_off_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
				lock_sb.check_result(rsp_ch.granted, rsp_ch.lock_state);
			if (phase == 2 && !hold_off_done) begin
				hold_left = HOLD_OFF_LEN;
				hold_off_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_req(input logic [MODE_W-1:0] m, input logic [HOST_W-1:0] h);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.host <= h;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		lock_sb.note_request(m, h);
		requests_sent++;
	endtask

	// drop every hold so that the next sequence starts from unlocked
	task automatic release_lock();
		int h;
		while (lock_sb.lock_mode != ST_UNLOCKED) begin
			h = 0;
			while (h < HOSTS_DEF - 1 && lock_sb.hold_cnt[h] == '0) h++;
			send_req(MODE_UNLOCK, h[HOST_W-1:0]);
		end
	endtask

	task automatic lock_episode();
		int kind;
		int n;
		logic [HOST_W-1:0] h;
		logic [HOST_W-1:0] base;
		logic [HOST_W-1:0] other;
		logic [MODE_W-1:0] m;
		kind = $urandom_range(99);
		if (kind < 15) begin
			n = $urandom_range(1, 4);
			repeat (n) send_req(MODE_W'($urandom_range(7)), HOST_W'($urandom_range(15)));
		end else if (kind < 50) begin
			if (lock_sb.lock_mode == ST_WRITE) release_lock();
			base = HOST_W'($urandom_range(12));
			n = $urandom_range(2, 10);
			repeat (n) begin
				h = base + HOST_W'($urandom_range(3));
				kind = $urandom_range(99);
				if (kind < 60) m = MODE_RD_LOCK;
				else if (kind < 85) m = $urandom_range(1) ? MODE_RD_UNLOCK : MODE_UNLOCK;
				else if (kind < 95) m = MODE_WR_LOCK;
				else m = MODE_WR_UNLOCK;
				send_req(m, h);
			end
			if ($urandom_range(1)) release_lock();
		end else if (kind < 85) begin
			release_lock();
			h = HOST_W'($urandom_range(15));
			n = $urandom_range(1, 5);
			repeat (n) begin
				send_req(MODE_WR_LOCK, h);
				if ($urandom_range(2) == 0) begin
					other = h + HOST_W'($urandom_range(1, 15));
					case ($urandom_range(4))
						0: m = MODE_RD_LOCK;
						1: m = MODE_WR_LOCK;
						2: m = MODE_WR_UNLOCK;
						3: m = MODE_UNLOCK;
						default: m = MODE_RD_UNLOCK;
					endcase
					send_req(m, other);
				end
				if ($urandom_range(5) == 0) send_req(MODE_RD_UNLOCK, h);
			end
			send_req($urandom_range(1) ? MODE_WR_UNLOCK : MODE_UNLOCK, h);
		end else begin
			n = $urandom_range(2, 8);
			repeat (n) send_req(MODE_W'($urandom_range(4)), HOST_W'($urandom_range(3)));
		end
	endtask

	initial begin
		logic [HOST_W-1:0] h;
		req_ch.valid <= 1'b0;
		req_ch.mode <= MODE_RD_LOCK;
		req_ch.host <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// refused while unlocked
		send_req(MODE_UNLOCK, 4'd0);
		send_req(MODE_RD_UNLOCK, 4'd15);
		send_req(MODE_WR_UNLOCK, 4'd0);
		// shared readers
		send_req(MODE_RD_LOCK, 4'd0);
		send_req(MODE_RD_LOCK, 4'd15);
		send_req(MODE_RD_LOCK, 4'd15);
		send_req(MODE_WR_LOCK, 4'd3);
		send_req(MODE_WR_UNLOCK, 4'd0);
		send_req(MODE_RD_UNLOCK, 4'd3);
		send_req(MODE_UNLOCK, 4'd15);
		send_req(MODE_RD_UNLOCK, 4'd15);
		send_req(MODE_RD_UNLOCK, 4'd0);
		// reentrant writer
		send_req(MODE_WR_LOCK, 4'd5);
		send_req(MODE_WR_LOCK, 4'd5);
		send_req(MODE_WR_LOCK, 4'd6);
		send_req(MODE_RD_LOCK, 4'd6);
		send_req(MODE_RD_UNLOCK, 4'd5);
		send_req(MODE_WR_UNLOCK, 4'd6);
		send_req(MODE_UNLOCK, 4'd5);
		// unused codes
		send_req(3'd5, 4'd10);
		send_req(3'd6, 4'd15);
		send_req(3'd7, 4'd0);
		send_req(MODE_WR_LOCK, 4'd10);
		send_req(MODE_WR_UNLOCK, 4'd10);

		while (requests_sent < PHASE_ITEMS) lock_episode();

		phase = 1;
		tx_idle_pct = 56;
		rx_idle_pct = 14;
		while (requests_sent < 2 * PHASE_ITEMS) lock_episode();

		phase = 2;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		// writer hold count to its limit, offered during the long result hold-off
		release_lock();
		h = HOST_W'($urandom_range(15));
		repeat (256) send_req(MODE_WR_LOCK, h);
		send_req(MODE_RD_LOCK, h + 4'd1);
		send_req(MODE_WR_UNLOCK, h);
		while (requests_sent < 2 * PHASE_ITEMS + 290) lock_episode();
		// reader hold count to its limit
		release_lock();
		h = HOST_W'($urandom_range(15));
		repeat (256) send_req(MODE_RD_LOCK, h);
		send_req(MODE_RD_LOCK, h + 4'd7);
		send_req(MODE_UNLOCK, h + 4'd7);
		send_req(MODE_RD_UNLOCK, h);
		req_ch.valid <= 1'b0;

		while (lock_sb.expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d requests, %0d results checked, %0d granted",
			requests_sent, lock_sb.results_checked, lock_sb.grants_seen);
		$display("incl. read and write hold saturation and a %0d-cycle result stall",
			HOLD_OFF_LEN);
		if (lock_sb.mismatches == 0 && lock_sb.expected_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", lock_sb.mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/rwl_pkg.sv
rtl/rwl_if.sv
rtl/rwl_hold_mem.sv
rtl/rwl_update.sv
rtl/reader_writer_lock_manager.sv
dv/reader_writer_lock_manager_test.sv
